// ===== rtl/core/transport_param_tlv_parser_core_assert.svh =====
// Assertion macros for the transport parameter parser core.
// Expands to concurrent assertions in simulation and to nothing in synthesis.
`ifndef TRANSPORT_PARAM_TLV_PARSER_CORE_ASSERT_SVH
`define TRANSPORT_PARAM_TLV_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define TPTLV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tptlv: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPTLV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tptlv: next-cycle check failed");

`else

`define TPTLV_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TPTLV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/tptlv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the transport parameter parser core.
// No dependencies.
package tptlv_pkg;

    // Bytes in the reset secret entry.
    localparam int SECRET_BYTES = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int FIFO_DEPTH = 4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEG_VER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_VER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUP_VER_0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUP_COUNT  = 3'd7;

    // Modes.
    localparam logic [1:0] MODE_CLIENT = 2'd0;
    localparam logic [1:0] MODE_SERVER = 2'd1;

    // Result kinds.
    localparam logic [3:0] KIND_STREAM_DATA = 4'd0;
    localparam logic [3:0] KIND_MAX_DATA    = 4'd1;
    localparam logic [3:0] KIND_BIDIR_RANK  = 4'd2;
    localparam logic [3:0] KIND_IDLE        = 4'd3;
    localparam logic [3:0] KIND_PACKET_SIZE = 4'd4;
    localparam logic [3:0] KIND_SECRET_HI   = 4'd5;
    localparam logic [3:0] KIND_SECRET_LO   = 4'd6;
    localparam logic [3:0] KIND_ACK_EXP     = 4'd7;
    localparam logic [3:0] KIND_UNIDIR_RANK = 4'd8;
    localparam logic [3:0] KIND_END         = 4'd9;

    // End status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_PARAM_ERR = 2'd1;
    localparam logic [1:0] STATUS_SPOOFED   = 2'd2;

    // Parameter type codes.
    localparam logic [15:0] TP_STREAM_DATA = 16'd0;
    localparam logic [15:0] TP_MAX_DATA    = 16'd1;
    localparam logic [15:0] TP_BIDIR_RANK  = 16'd2;
    localparam logic [15:0] TP_IDLE        = 16'd3;
    localparam logic [15:0] TP_PACKET_SIZE = 16'd5;
    localparam logic [15:0] TP_SECRET      = 16'd6;
    localparam logic [15:0] TP_ACK_EXP     = 16'd7;
    localparam logic [15:0] TP_UNIDIR_RANK = 16'd8;

    localparam logic [7:0]  LIST_MAX       = 8'd252;
    localparam logic [15:0] TRACKED_TYPES  = 16'd64;

    typedef enum logic [7:0] {
        PH_START    = 8'b0000_0001,
        PH_VER      = 8'b0000_0010,
        PH_LIST_LEN = 8'b0000_0100,
        PH_LIST     = 8'b0000_1000,
        PH_SIZE     = 8'b0001_0000,
        PH_HDR      = 8'b0010_0000,
        PH_VAL      = 8'b0100_0000,
        PH_SKIP     = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [1:0]  status;
        logic [15:0] consumed;
        logic        last;
    } result_t;

    function automatic logic [3:0] kind_of_type(input logic [15:0] t);
        logic [3:0] k;
        unique case (t)
            TP_MAX_DATA:    k = KIND_MAX_DATA;
            TP_BIDIR_RANK:  k = KIND_BIDIR_RANK;
            TP_IDLE:        k = KIND_IDLE;
            TP_PACKET_SIZE: k = KIND_PACKET_SIZE;
            TP_SECRET:      k = KIND_SECRET_LO;
            TP_ACK_EXP:     k = KIND_ACK_EXP;
            TP_UNIDIR_RANK: k = KIND_UNIDIR_RANK;
            default:        k = KIND_STREAM_DATA;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/transport_param_tlv_parser_core.sv =====
`timescale 1ns / 1ps
// Transport parameter parser: one message byte per cycle in while s_tready is high, parameter results out.
// Results are written into a registered result queue and shown on m_tvalid from its head.
// Throughput: one byte per cycle while s_tready is high; the parse step is a single registered pass per byte.
// A byte can yield two results, a parameter result and an end result; a four-entry result
// queue holds them, and s_tready drops while fewer than two entries are free.
// Reset: parse state returns to header start, registers to defaults, queue empties.
// Depends on tptlv_pkg and transport_param_tlv_parser_core_assert.svh.
`include "transport_param_tlv_parser_core_assert.svh"

module transport_param_tlv_parser_core
    import tptlv_pkg::*;
#(
    parameter int MAX_VERSIONS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input bytes
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // frame_end
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [87:0]           m_tdata,   // [63:0] value, [65:64] status, [81:66] consumed
    output logic [3:0]            m_tuser,   // [3:0] kind
    output logic                  m_tlast,   // last
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // configuration
    logic [1:0]  mode_reg;
    logic [31:0] neg_ver_reg;
    logic [31:0] prop_ver_reg;
    logic [31:0] sup_ver_reg [MAX_VERSIONS];
    logic [2:0]  sup_cnt_reg;

    // parse state
    phase_t      phase_reg,   phase_next;
    logic [15:0] bpos_reg,    bpos_next;
    logic [15:0] fleft_reg,   fleft_next;
    logic [7:0]  lleft_reg,   lleft_next;
    logic [15:0] pend_reg,    pend_next;
    logic [15:0] etype_reg,   etype_next;
    logic [63:0] vshift_reg,  vshift_next;
    logic [63:0] mask_reg,    mask_next;
    logic [15:0] resume_reg,  resume_next;
    logic        fin_reg,     fin_next;

    // result queue
    result_t            q_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic        s_fire;
    logic        m_fire;
    logic [63:0] vs_base;
    logic [63:0] vs_sh;
    logic [2:0]  cnt_eff;
    logic        is_sup;

    logic        pv;
    logic [3:0]  pkind;
    logic [63:0] pval;
    logic        ev;
    logic [1:0]  est;
    logic [15:0] econs;
    result_t     res0;
    result_t     res1;
    logic [1:0]  push_n;
    result_t     head;

    assign cfg_ready = 1'b1;
    assign s_tready  = (cnt_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;

    // ------------------------------------------------------------------
    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_CLIENT;
            neg_ver_reg  <= '0;
            prop_ver_reg <= '0;
            sup_cnt_reg  <= 3'd1;
            for (int i = 0; i < MAX_VERSIONS; i++)
            begin
                sup_ver_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_MODE)
            begin
                mode_reg <= cfg_data[1:0];
            end
            if (cfg_index == REG_NEG_VER)
            begin
                neg_ver_reg <= cfg_data;
            end
            if (cfg_index == REG_PROP_VER)
            begin
                prop_ver_reg <= cfg_data;
            end
            if (cfg_index == REG_SUP_COUNT)
            begin
                sup_cnt_reg <= cfg_data[2:0];
            end
            for (int i = 0; i < MAX_VERSIONS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_SUP_VER_0 + CFG_IDX_W'(i)))
                begin
                    sup_ver_reg[i] <= cfg_data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shift in the byte; a fresh message starts from an empty shift register
    assign vs_base = (phase_reg == PH_START) ? 64'd0 : vshift_reg;
    assign vs_sh   = {vs_base[55:0], s_tdata};
    assign cnt_eff = (sup_cnt_reg > 3'(MAX_VERSIONS)) ? 3'(MAX_VERSIONS) : sup_cnt_reg;

    always_comb
    begin
        is_sup = 1'b0;
        for (int i = 0; i < MAX_VERSIONS; i++)
        begin
            if ((3'(i) < cnt_eff) && (sup_ver_reg[i] == vs_sh[31:0]))
            begin
                is_sup = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // one parse step per accepted byte
    always_comb
    begin
        logic        boundary;
        logic [15:0] t;
        logic [15:0] len;
        logic [16:0] size_sum;
        logic [16:0] hdr_sum;
        logic [15:0] room;
        logic        err;
        logic        known;
        logic [63:0] need;

        phase_next  = phase_reg;
        bpos_next   = bpos_reg;
        fleft_next  = fleft_reg;
        lleft_next  = lleft_reg;
        pend_next   = pend_reg;
        etype_next  = etype_reg;
        vshift_next = vshift_reg;
        mask_next   = mask_reg;
        resume_next = resume_reg;
        fin_next    = fin_reg;

        pv    = 1'b0;
        pkind = KIND_STREAM_DATA;
        pval  = '0;
        ev    = 1'b0;
        est   = STATUS_OK;
        econs = '0;

        boundary = 1'b0;
        t        = vs_sh[31:16];
        len      = vs_sh[15:0];
        size_sum = '0;
        hdr_sum  = '0;
        room     = '0;
        err      = 1'b0;
        known    = 1'b1;
        need     = 64'h0B;

        if (fin_reg)
        begin
            // drop trailing bytes until the frame ends
            if (s_tlast)
            begin
                fin_next = 1'b0;
                phase_next = PH_START;
                bpos_next = '0;
                fleft_next = '0;
                lleft_next = '0;
                pend_next = '0;
                etype_next = '0;
                vshift_next = '0;
                mask_next = '0;
                resume_next = '0;
            end
        end
        else
        begin
            if (phase_reg == PH_START)
            begin
                resume_next = '0;
                if (mode_reg == MODE_CLIENT || mode_reg == MODE_SERVER)
                begin
                    phase_next = PH_VER;
                    fleft_next = 16'd4;
                end
                else
                begin
                    phase_next = PH_SIZE;
                    fleft_next = 16'd2;
                end
            end
            bpos_next   = bpos_reg + 16'd1;
            vshift_next = vs_sh;

            unique case (phase_next)
                PH_VER:
                begin
                    fleft_next = fleft_next - 16'd1;
                    if (fleft_next == 16'd0)
                    begin
                        if (mode_reg == MODE_CLIENT)
                        begin
                            if (vs_sh[31:0] != neg_ver_reg && is_sup)
                            begin
                                ev = 1'b1; est = STATUS_SPOOFED; econs = bpos_next;
                            end
                            else
                            begin
                                phase_next = PH_SIZE; fleft_next = 16'd2;
                                vshift_next = '0; resume_next = bpos_next;
                            end
                        end
                        else if (vs_sh[31:0] != neg_ver_reg)
                        begin
                            ev = 1'b1; est = STATUS_SPOOFED; econs = bpos_next;
                        end
                        else
                        begin
                            phase_next = PH_LIST_LEN; resume_next = bpos_next;
                        end
                    end
                end
                PH_LIST_LEN:
                begin
                    if (s_tdata[1:0] != 2'd0 || s_tdata > LIST_MAX)
                    begin
                        ev = 1'b1; est = STATUS_PARAM_ERR; econs = bpos_next;
                    end
                    else
                    begin
                        resume_next = bpos_next;
                        if (s_tdata == 8'd0)
                        begin
                            phase_next = PH_SIZE; fleft_next = 16'd2; vshift_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_LIST; lleft_next = s_tdata;
                            fleft_next = 16'd4; vshift_next = '0;
                        end
                    end
                end
                PH_LIST:
                begin
                    lleft_next = lleft_next - 8'd1;
                    fleft_next = fleft_next - 16'd1;
                    if (fleft_next == 16'd0)
                    begin
                        if (prop_ver_reg != neg_ver_reg && vs_sh[31:0] == prop_ver_reg)
                        begin
                            ev = 1'b1; est = STATUS_SPOOFED; econs = bpos_next;
                        end
                        else
                        begin
                            fleft_next = 16'd4; vshift_next = '0;
                            if (lleft_next == 8'd0)
                            begin
                                phase_next = PH_SIZE; fleft_next = 16'd2;
                                resume_next = bpos_next;
                            end
                        end
                    end
                end
                PH_SIZE:
                begin
                    fleft_next = fleft_next - 16'd1;
                    if (fleft_next == 16'd0)
                    begin
                        size_sum = {1'b0, bpos_next} + {1'b0, vs_sh[15:0]};
                        pend_next = size_sum[15:0];
                        if (size_sum[16])
                        begin
                            ev = 1'b1; est = STATUS_PARAM_ERR; econs = bpos_next;
                        end
                        else
                        begin
                            resume_next = bpos_next;
                            boundary = 1'b1;
                        end
                    end
                end
                PH_HDR:
                begin
                    fleft_next = fleft_next - 16'd1;
                    if (fleft_next == 16'd0)
                    begin
                        etype_next = t;
                        hdr_sum = {1'b0, bpos_next} + {1'b0, len};
                        if (hdr_sum > {1'b0, pend_reg})
                        begin
                            ev = 1'b1; est = STATUS_PARAM_ERR; econs = bpos_next;
                        end
                        else
                        begin
                            if (t < TRACKED_TYPES)
                            begin
                                err = mask_reg[t[5:0]];
                                mask_next[t[5:0]] = 1'b1;
                            end
                            unique case (t)
                                TP_STREAM_DATA, TP_MAX_DATA:
                                    err = err || (len != 16'd4);
                                TP_BIDIR_RANK, TP_IDLE, TP_PACKET_SIZE, TP_UNIDIR_RANK:
                                    err = err || (len != 16'd2);
                                TP_ACK_EXP:
                                    err = err || (len != 16'd1);
                                TP_SECRET:
                                    err = err || (mode_reg != MODE_SERVER)
                                              || (len != 16'(SECRET_BYTES));
                                default:
                                    known = 1'b0;
                            endcase
                            if (err)
                            begin
                                ev = 1'b1; est = STATUS_PARAM_ERR; econs = bpos_next;
                            end
                            else if (len == 16'd0)
                            begin
                                boundary = 1'b1;
                            end
                            else
                            begin
                                fleft_next = len;
                                vshift_next = '0;
                                phase_next = known ? PH_VAL : PH_SKIP;
                                // a short secret has no high part: report it empty now
                                if (t == TP_SECRET && SECRET_BYTES <= 8)
                                begin
                                    pv = 1'b1; pkind = KIND_SECRET_HI; pval = '0;
                                end
                            end
                        end
                    end
                end
                PH_VAL:
                begin
                    fleft_next = fleft_next - 16'd1;
                    if (etype_reg == TP_SECRET && SECRET_BYTES > 8 && fleft_next == 16'd8)
                    begin
                        pv = 1'b1; pkind = KIND_SECRET_HI; pval = vs_sh;
                        vshift_next = '0;
                    end
                    if (fleft_next == 16'd0)
                    begin
                        pv = 1'b1; pkind = kind_of_type(etype_reg); pval = vs_sh;
                        boundary = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    fleft_next = fleft_next - 16'd1;
                    if (fleft_next == 16'd0)
                    begin
                        boundary = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // entry boundary: block complete, header cut short, or next header
            if (boundary)
            begin
                room = pend_next - bpos_next;
                if (mode_reg == MODE_SERVER)
                begin
                    need = 64'h4B;
                end
                if (bpos_next == pend_next)
                begin
                    ev = 1'b1;
                    est = ((mask_next & need) == need) ? STATUS_OK : STATUS_PARAM_ERR;
                    econs = bpos_next;
                end
                else if (room < 16'd4)
                begin
                    ev = 1'b1; est = STATUS_PARAM_ERR; econs = bpos_next;
                end
                else
                begin
                    phase_next = PH_HDR; fleft_next = 16'd4; vshift_next = '0;
                end
            end

            if (ev)
            begin
                fin_next = 1'b1;
            end

            if (s_tlast)
            begin
                if (!ev)
                begin
                    ev = 1'b1; est = STATUS_PARAM_ERR; econs = resume_next;
                end
                fin_next = 1'b0;
                phase_next = PH_START;
                bpos_next = '0;
                fleft_next = '0;
                lleft_next = '0;
                pend_next = '0;
                etype_next = '0;
                vshift_next = '0;
                mask_next = '0;
                resume_next = '0;
            end
        end
    end

    // parameter result goes first, the end result after it
    always_comb
    begin
        res1.kind     = KIND_END;
        res1.value    = '0;
        res1.status   = est;
        res1.consumed = econs;
        res1.last     = 1'b1;
        if (pv)
        begin
            res0.kind     = pkind;
            res0.value    = pval;
            res0.status   = STATUS_OK;
            res0.consumed = '0;
            res0.last     = 1'b0;
        end
        else
        begin
            res0 = res1;
        end
        push_n = s_fire ? ({1'b0, pv} + {1'b0, ev}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            bpos_reg   <= '0;
            fleft_reg  <= '0;
            lleft_reg  <= '0;
            pend_reg   <= '0;
            etype_reg  <= '0;
            vshift_reg <= '0;
            mask_reg   <= '0;
            resume_reg <= '0;
            fin_reg    <= 1'b0;
        end
        else if (s_fire)
        begin
            phase_reg  <= phase_next;
            bpos_reg   <= bpos_next;
            fleft_reg  <= fleft_next;
            lleft_reg  <= lleft_next;
            pend_reg   <= pend_next;
            etype_reg  <= etype_next;
            vshift_reg <= vshift_next;
            mask_reg   <= mask_next;
            resume_reg <= resume_next;
            fin_reg    <= fin_next;
        end
    end

    // ------------------------------------------------------------------
    // result queue
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            q_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (m_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + CNT_W'(push_n) - CNT_W'(m_fire);
        end
    end

    assign head     = q_mem[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {6'd0, head.consumed, head.status, head.value};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    // ------------------------------------------------------------------
    `TPTLV_ASSERT_IMPLY(a_q_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(FIFO_DEPTH))
    `TPTLV_ASSERT_IMPLY(a_pair_ends, clk, rst_n, push_n == 2'd2, res1.last && !res0.last)
    `TPTLV_ASSERT_IMPLY(a_quiet_after_end, clk, rst_n, fin_reg, push_n == 2'd0)
    `TPTLV_ASSERT_NEXT(a_rearm, clk, rst_n, s_fire && s_tlast, !fin_reg && phase_reg == PH_START)

endmodule
